// File: hdl/jfk_pkg.sv
// ----------------------------------------------------------------------------
// Joint forward kinematics package
// Shared widths, sequencer codes, microprogram and CORDIC constants.
// ----------------------------------------------------------------------------
package jfk_pkg;

   localparam int ID_W     = 6;
   localparam int IDX_W    = 4;
   localparam int ANGLE_W  = 26;
   localparam int VAL_W    = 32;
   localparam int CS_W     = 33;
   localparam int Z_W      = 27;
   localparam int LOC_W    = 35;
   localparam int MUL_W    = 70;
   localparam int ACC_W    = 72;
   localparam int ENTRIES  = 12;
   localparam int CORDIC_STEPS = 20;

   localparam logic [3:0] UOP_LAST = 4'd13;

   localparam logic signed [Z_W-1:0]  DEG_HALF    = 27'sd11796480;
   localparam logic signed [Z_W-1:0]  DEG_FULL    = 27'sd23592960;
   localparam logic signed [Z_W-1:0]  DEG_QUARTER = 27'sd5898240;
   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [3:0] DST_L00 = 4'd0;
   localparam logic [3:0] DST_L01 = 4'd1;
   localparam logic [3:0] DST_L02 = 4'd2;
   localparam logic [3:0] DST_L10 = 4'd3;
   localparam logic [3:0] DST_L11 = 4'd4;
   localparam logic [3:0] DST_L12 = 4'd5;
   localparam logic [3:0] DST_L20 = 4'd6;
   localparam logic [3:0] DST_L21 = 4'd7;
   localparam logic [3:0] DST_L22 = 4'd8;
   localparam logic [3:0] DST_BD  = 4'd9;
   localparam logic [3:0] DST_BC  = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_COR_START,
      ST_COR_WAIT,
      ST_LMUL,
      ST_LACC,
      ST_ROOT_OUT,
      ST_PLOAD,
      ST_GMUL,
      ST_GACC,
      ST_GOUT
   } jfk_state_type;

   typedef enum logic [2:0] {
      SRC_A, SRC_B, SRC_C, SRC_D, SRC_E, SRC_F, SRC_BD, SRC_BC
   } src_type;

   typedef enum logic [1:0] {
      MODE_SET, MODE_ADD, MODE_SUB, MODE_NEG
   } mode_type;

   typedef struct packed {
      src_type    src_a;
      src_type    src_b;
      mode_type   mode;
      logic [3:0] dst;
   } uop_type;

   typedef struct packed {
      logic                      start;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [CS_W-1:0] sin_val;
      logic signed [CS_W-1:0] cos_val;
   } cordic_rsp_type;

   function automatic uop_type uop_at(input logic [3:0] step);
      uop_type u;
      unique case (step)
         4'd0:    u = '{SRC_B,  SRC_D, MODE_SET, DST_BD};
         4'd1:    u = '{SRC_B,  SRC_C, MODE_SET, DST_BC};
         4'd2:    u = '{SRC_C,  SRC_E, MODE_SET, DST_L00};
         4'd3:    u = '{SRC_BD, SRC_F, MODE_SUB, DST_L00};
         4'd4:    u = '{SRC_A,  SRC_F, MODE_NEG, DST_L01};
         4'd5:    u = '{SRC_D,  SRC_E, MODE_SET, DST_L02};
         4'd6:    u = '{SRC_BC, SRC_F, MODE_ADD, DST_L02};
         4'd7:    u = '{SRC_C,  SRC_F, MODE_SET, DST_L10};
         4'd8:    u = '{SRC_BD, SRC_E, MODE_ADD, DST_L10};
         4'd9:    u = '{SRC_A,  SRC_E, MODE_SET, DST_L11};
         4'd10:   u = '{SRC_D,  SRC_F, MODE_SET, DST_L12};
         4'd11:   u = '{SRC_BC, SRC_E, MODE_SUB, DST_L12};
         4'd12:   u = '{SRC_A,  SRC_D, MODE_NEG, DST_L20};
         4'd13:   u = '{SRC_A,  SRC_C, MODE_SET, DST_L22};
         default: u = '{SRC_A,  SRC_C, MODE_SET, DST_L22};
      endcase
      return u;
   endfunction

   function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] i);
      logic signed [Z_W-1:0] v;
      unique case (i)
         5'd0:    v = 27'sd2949120;
         5'd1:    v = 27'sd1740967;
         5'd2:    v = 27'sd919879;
         5'd3:    v = 27'sd466945;
         5'd4:    v = 27'sd234379;
         5'd5:    v = 27'sd117305;
         5'd6:    v = 27'sd58666;
         5'd7:    v = 27'sd29335;
         5'd8:    v = 27'sd14668;
         5'd9:    v = 27'sd7334;
         5'd10:   v = 27'sd3667;
         5'd11:   v = 27'sd1833;
         5'd12:   v = 27'sd917;
         5'd13:   v = 27'sd458;
         5'd14:   v = 27'sd229;
         5'd15:   v = 27'sd115;
         5'd16:   v = 27'sd57;
         5'd17:   v = 27'sd29;
         5'd18:   v = 27'sd14;
         5'd19:   v = 27'sd7;
         default: v = 27'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/jfk_cordic.sv
// ----------------------------------------------------------------------------
// Joint forward kinematics CORDIC
// Iterative sine and cosine of a Q9.16 degree angle, one rotation per cycle.
// ----------------------------------------------------------------------------
module jfk_cordic import jfk_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [4:0]             iter_ff, iter_in;
   logic signed [CS_W-1:0] x_ff, x_in;
   logic signed [CS_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic                   neg_ff, neg_in;

   logic signed [Z_W-1:0]  r0, r1, r2;
   logic                   fold;
   logic signed [CS_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  at;

   always_comb begin
      r0 = Z_W'(req.angle);
      if (r0 >= DEG_HALF) begin
         r1 = r0 - DEG_FULL;
      end else if (r0 < -DEG_HALF) begin
         r1 = r0 + DEG_FULL;
      end else begin
         r1 = r0;
      end
      fold = 1'b1;
      if (r1 > DEG_QUARTER) begin
         r2 = DEG_HALF - r1;
      end else if (r1 < -DEG_QUARTER) begin
         r2 = -DEG_HALF - r1;
      end else begin
         r2   = r1;
         fold = 1'b0;
      end
   end

   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = atan_deg(iter_ff);
      run_in  = run_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         run_in  = 1'b1;
         iter_in = 5'd0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = r2;
         neg_in  = fold;
      end else if (run_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 5'd1;
         if (iter_ff == 5'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.sin_val = y_ff;
   assign rsp.cos_val = neg_ff ? -x_ff : x_ff;

endmodule

// File: hdl/joint_forward_kinematics.sv
// ----------------------------------------------------------------------------
// Joint forward kinematics
// Local 4x4 transform from Euler angles and offset, chained (unless the joint
// is a root) onto the parent's stored matrix; 12 entries emitted and stored.
// ----------------------------------------------------------------------------
// Sequence: three CORDIC runs, 14 products on the shared multiplier, then 12
// entries of 3 multiply-accumulates plus 4 parent-row reads per row; a root
// skips the parent stage and an end joint skips the CORDIC and local products.
// Requests are accepted only while idle; busy stays high until the last entry.
// Results stream as 12 one-cycle strobes; the receiver cannot stall.
// Reset clears the sequencer; the matrix store is undefined until written.
module joint_forward_kinematics import jfk_pkg::*; #(
   parameter int MAX_JOINTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ID_W-1:0]          req_joint_id,
   input  logic [ID_W-1:0]          req_parent_id,
   input  logic                     req_is_root,
   input  logic                     req_is_end,
   input  logic signed [ANGLE_W-1:0] req_angle_0,
   input  logic signed [ANGLE_W-1:0] req_angle_1,
   input  logic signed [ANGLE_W-1:0] req_angle_2,
   input  logic signed [VAL_W-1:0]  req_offset_x,
   input  logic signed [VAL_W-1:0]  req_offset_y,
   input  logic signed [VAL_W-1:0]  req_offset_z,
   output logic                     rsp_valid,
   output logic [ID_W-1:0]          rsp_out_joint,
   output logic [IDX_W-1:0]         rsp_entry_index,
   output logic signed [VAL_W-1:0]  rsp_entry_value,
   output logic                     rsp_last
);

   localparam int DEPTH = MAX_JOINTS * ENTRIES;
   localparam int AW    = $clog2(DEPTH);

   localparam logic signed [MUL_W-1:0] HALF_M = MUL_W'(64'sd536870912);
   localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(64'sd536870912);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

   function automatic logic [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [VAL_W-1:0] r;
      if (v > SAT_HI) begin
         r = 32'h7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'h80000000;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   jfk_state_type state_ff, state_in;

   logic [ID_W-1:0]            jid_ff, jid_in;
   logic [ID_W-1:0]            jr_ff, jr_in;
   logic [ID_W-1:0]            pr_ff, pr_in;
   logic                       root_ff, root_in;
   logic                       end_ff, end_in;
   logic signed [ANGLE_W-1:0]  ang0_ff, ang0_in, ang1_ff, ang1_in, ang2_ff, ang2_in;
   logic signed [VAL_W-1:0]    offx_ff, offx_in, offy_ff, offy_in, offz_ff, offz_in;
   logic [1:0]                 sel_ff, sel_in;
   logic [3:0]                 step_ff, step_in;
   logic signed [LOC_W-1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [LOC_W-1:0]    d_ff, d_in, e_ff, e_in, f_ff, f_in;
   logic signed [LOC_W-1:0]    bd_ff, bd_in, bc_ff, bc_in;
   logic signed [LOC_W-1:0]    lacc_ff, lacc_in;
   logic signed [LOC_W-1:0]    loc_ff [9];
   logic signed [LOC_W-1:0]    loc_in [9];
   logic [1:0]                 row_ff, row_in, col_ff, col_in, k_ff, k_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic signed [VAL_W-1:0]    prow_ff [4];
   logic signed [VAL_W-1:0]    prow_in [4];
   logic signed [MUL_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [VAL_W-1:0]    rdata_ff;
   logic [VAL_W-1:0]           mem [DEPTH];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [ID_W-1:0]            rsp_joint_ff, rsp_joint_in;
   logic [IDX_W-1:0]           rsp_index_ff, rsp_index_in;
   logic [VAL_W-1:0]           rsp_value_ff, rsp_value_in;

   cordic_req_type             cor_req;
   cordic_rsp_type             cor_rsp;

   uop_type                    uop;
   logic                       accept;
   logic                       slots_ok;
   logic                       emit, mem_we, mem_re;
   logic [1:0]                 lrow, lcol;
   logic [3:0]                 li;
   logic signed [LOC_W-1:0]    loc_val, src_a_val, src_b_val, mul_a, mul_b;
   logic signed [MUL_W-1:0]    rnd_m;
   logic signed [LOC_W-1:0]    lres, lnew;
   logic signed [ACC_W-1:0]    tot, trnd;
   logic [VAL_W-1:0]           out_val;
   logic [AW-1:0]              waddr, raddr;

   jfk_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cor_req),
      .rsp   (cor_rsp)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign uop      = uop_at(step_ff);
   assign slots_ok = ({5'd0, jr_ff} < 11'(MAX_JOINTS)) && ({5'd0, pr_ff} < 11'(MAX_JOINTS));

   always_comb begin
      lrow = (state_ff == ST_GMUL) ? k_ff : row_ff;
      lcol = col_ff;
      li   = {2'b00, lrow} + {1'b0, lrow, 1'b0} + {2'b00, lcol};
      if (lcol == 2'd3) begin
         unique case (lrow)
            2'd0:    loc_val = LOC_W'(offx_ff);
            2'd1:    loc_val = LOC_W'(offy_ff);
            default: loc_val = LOC_W'(offz_ff);
         endcase
      end else if (end_ff) begin
         loc_val = '0;
      end else if (li == DST_L21) begin
         loc_val = b_ff;
      end else begin
         loc_val = loc_ff[li];
      end
   end

   always_comb begin
      unique case (uop.src_a)
         SRC_A:   src_a_val = a_ff;
         SRC_B:   src_a_val = b_ff;
         SRC_C:   src_a_val = c_ff;
         SRC_D:   src_a_val = d_ff;
         SRC_E:   src_a_val = e_ff;
         SRC_F:   src_a_val = f_ff;
         SRC_BD:  src_a_val = bd_ff;
         default: src_a_val = bc_ff;
      endcase
      unique case (uop.src_b)
         SRC_A:   src_b_val = a_ff;
         SRC_B:   src_b_val = b_ff;
         SRC_C:   src_b_val = c_ff;
         SRC_D:   src_b_val = d_ff;
         SRC_E:   src_b_val = e_ff;
         SRC_F:   src_b_val = f_ff;
         SRC_BD:  src_b_val = bd_ff;
         default: src_b_val = bc_ff;
      endcase
   end

   always_comb begin
      if (state_ff == ST_GMUL) begin
         mul_a = LOC_W'(prow_ff[k_ff]);
         mul_b = loc_val;
      end else begin
         mul_a = src_a_val;
         mul_b = src_b_val;
      end
      prod_in = MUL_W'(mul_a) * MUL_W'(mul_b);
      rnd_m   = (prod_ff + HALF_M) >>> 30;
      lres    = rnd_m[LOC_W-1:0];
      unique case (uop.mode)
         MODE_SET: lnew = lres;
         MODE_ADD: lnew = lacc_ff + lres;
         MODE_SUB: lnew = lacc_ff - lres;
         default:  lnew = -lres;
      endcase
      tot  = acc_ff + ((col_ff == 2'd3) ? (ACC_W'(prow_ff[3]) <<< 30) : ACC_W'(0));
      trnd = (tot + HALF_A) >>> 30;
      if (state_ff == ST_ROOT_OUT) begin
         out_val = sat32(ACC_W'(loc_val));
      end else begin
         out_val = sat32(trnd);
      end
      waddr = AW'(32'(jr_ff) * 32'd12 + 32'({row_ff, col_ff}));
      raddr = AW'(32'(pr_ff) * 32'd12 + 32'({row_ff, cnt_ff[1:0]}));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (slots_ok) begin
               if (!end_ff) begin
                  state_in = ST_COR_START;
               end else if (root_ff) begin
                  state_in = ST_ROOT_OUT;
               end else begin
                  state_in = ST_PLOAD;
               end
            end
         end
         ST_COR_START: state_in = ST_COR_WAIT;
         ST_COR_WAIT: begin
            if (cor_rsp.done) begin
               state_in = (sel_ff == 2'd2) ? ST_LMUL : ST_COR_START;
            end
         end
         ST_LMUL: state_in = ST_LACC;
         ST_LACC: begin
            if (step_ff == UOP_LAST) begin
               state_in = root_ff ? ST_ROOT_OUT : ST_PLOAD;
            end else begin
               state_in = ST_LMUL;
            end
         end
         ST_ROOT_OUT: begin
            if (row_ff == 2'd2 && col_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_PLOAD: begin
            if (cnt_ff == 3'd4) begin
               state_in = ST_GMUL;
            end
         end
         ST_GMUL: state_in = ST_GACC;
         ST_GACC: begin
            state_in = (k_ff == 2'd2) ? ST_GOUT : ST_GMUL;
         end
         ST_GOUT: begin
            if (col_ff == 2'd3) begin
               state_in = (row_ff == 2'd2) ? ST_IDLE : ST_PLOAD;
            end else begin
               state_in = ST_GMUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cor_req.start = (state_ff == ST_COR_START);
      unique case (sel_ff)
         2'd0:    cor_req.angle = ang0_ff;
         2'd1:    cor_req.angle = ang1_ff;
         default: cor_req.angle = ang2_ff;
      endcase
      emit   = (state_ff == ST_ROOT_OUT) || (state_ff == ST_GOUT);
      mem_we = emit;
      mem_re = (state_ff == ST_PLOAD) && (cnt_ff != 3'd4);
   end

   always_comb begin
      jid_in  = jid_ff;
      jr_in   = jr_ff;
      pr_in   = pr_ff;
      root_in = root_ff;
      end_in  = end_ff;
      ang0_in = ang0_ff;
      ang1_in = ang1_ff;
      ang2_in = ang2_ff;
      offx_in = offx_ff;
      offy_in = offy_ff;
      offz_in = offz_ff;
      sel_in  = sel_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      d_in    = d_ff;
      e_in    = e_ff;
      f_in    = f_ff;
      bd_in   = bd_ff;
      bc_in   = bc_ff;
      lacc_in = lacc_ff;
      loc_in  = loc_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      prow_in = prow_ff;
      acc_in  = acc_ff;
      rsp_valid_in = emit;
      rsp_last_in  = emit && (row_ff == 2'd2) && (col_ff == 2'd3);
      rsp_joint_in = rsp_joint_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               jid_in  = req_joint_id;
               jr_in   = req_joint_id;
               pr_in   = req_parent_id;
               root_in = req_is_root;
               end_in  = req_is_end;
               ang0_in = req_angle_0;
               ang1_in = req_angle_1;
               ang2_in = req_angle_2;
               offx_in = req_offset_x;
               offy_in = req_offset_y;
               offz_in = req_offset_z;
               sel_in  = 2'd0;
               step_in = 4'd0;
               row_in  = 2'd0;
               col_in  = 2'd0;
               k_in    = 2'd0;
               cnt_in  = 3'd0;
            end
         end
         ST_REDUCE: begin
            if ({5'd0, jr_ff} >= 11'(MAX_JOINTS)) begin
               jr_in = jr_ff - ID_W'(MAX_JOINTS);
            end
            if ({5'd0, pr_ff} >= 11'(MAX_JOINTS)) begin
               pr_in = pr_ff - ID_W'(MAX_JOINTS);
            end
         end
         ST_COR_WAIT: begin
            if (cor_rsp.done) begin
               unique case (sel_ff)
                  2'd0: begin
                     f_in = LOC_W'(cor_rsp.sin_val);
                     e_in = LOC_W'(cor_rsp.cos_val);
                  end
                  2'd1: begin
                     b_in = LOC_W'(cor_rsp.sin_val);
                     a_in = LOC_W'(cor_rsp.cos_val);
                  end
                  default: begin
                     d_in = LOC_W'(cor_rsp.sin_val);
                     c_in = LOC_W'(cor_rsp.cos_val);
                  end
               endcase
               sel_in = sel_ff + 2'd1;
            end
         end
         ST_LMUL: prod_in_hold: begin
         end
         ST_LACC: begin
            lacc_in = lnew;
            if (uop.dst == DST_BD) begin
               bd_in = lnew;
            end else if (uop.dst == DST_BC) begin
               bc_in = lnew;
            end else begin
               loc_in[uop.dst] = lnew;
            end
            step_in = step_ff + 4'd1;
         end
         ST_ROOT_OUT: begin
            rsp_joint_in = jid_ff;
            rsp_index_in = {row_ff, col_ff};
            rsp_value_in = out_val;
            if (col_ff == 2'd3) begin
               row_in = row_ff + 2'd1;
            end
            col_in = col_ff + 2'd1;
         end
         ST_PLOAD: begin
            if (cnt_ff != 3'd0) begin
               prow_in[cnt_ff[1:0] - 2'd1] = rdata_ff;
            end
            cnt_in = cnt_ff + 3'd1;
            k_in   = 2'd0;
         end
         ST_GACC: begin
            acc_in = ((k_ff == 2'd0) ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
            k_in   = k_ff + 2'd1;
         end
         ST_GOUT: begin
            rsp_joint_in = jid_ff;
            rsp_index_in = {row_ff, col_ff};
            rsp_value_in = out_val;
            k_in = 2'd0;
            if (col_ff == 2'd3) begin
               row_in = row_ff + 2'd1;
               cnt_in = 3'd0;
            end
            col_in = col_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      jid_ff  <= jid_in;
      jr_ff   <= jr_in;
      pr_ff   <= pr_in;
      root_ff <= root_in;
      end_ff  <= end_in;
      ang0_ff <= ang0_in;
      ang1_ff <= ang1_in;
      ang2_ff <= ang2_in;
      offx_ff <= offx_in;
      offy_ff <= offy_in;
      offz_ff <= offz_in;
      sel_ff  <= sel_in;
      step_ff <= step_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      f_ff    <= f_in;
      bd_ff   <= bd_in;
      bc_ff   <= bc_in;
      lacc_ff <= lacc_in;
      loc_ff  <= loc_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      prow_ff <= prow_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rsp_joint_ff <= rsp_joint_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= out_val;
      end
      if (mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_out_joint   = rsp_joint_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_value = rsp_value_ff;

endmodule

// File: hdl/jfk_checker.sv
// ----------------------------------------------------------------------------
// Joint forward kinematics port checks
// Port-level checks on request acceptance and the result strobe sequence.
// ----------------------------------------------------------------------------
module jfk_port_checks import jfk_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [ID_W-1:0]           rsp_out_joint,
   input logic [IDX_W-1:0]          rsp_entry_index,
   input logic                      rsp_last
);

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(ENTRIES - 1);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted request");

   a_rsp_in_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe outside a request");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid && rsp_entry_index == LAST_INDEX)
      else $error("last flag not on the final entry");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> !busy)
      else $error("still busy with the final entry");

   a_joint_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_index != '0 |-> rsp_out_joint == $past(rsp_out_joint))
      else $error("joint changed within one request");

endmodule

bind joint_forward_kinematics jfk_port_checks u_jfk_port_checks (.*);
